[sv/bisection_rank_pivot_search_top_macros.svh]
// Assertion macros for the bisection rank pivot search block.
// Used by bisection_rank_pivot_search_top; expects i_clk and i_rst_n in scope.
`ifndef BISECTION_RANK_PIVOT_SEARCH_TOP_MACROS_SVH
`define BISECTION_RANK_PIVOT_SEARCH_TOP_MACROS_SVH

// same-cycle implication
`define BRPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BRPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[sv/brps_pkg.sv]
// Shared types for the bisection rank pivot search block.
// No dependencies; imported by brps_store_scan, the top level and the testbench.
package brps_pkg;

    typedef struct packed {
        logic signed [31:0] sample;
        logic               last;
        logic        [10:0] target_rank;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] pivot_value;
        logic               exact_match;
        logic        [10:0] final_count;
    } t_out_word;

    typedef struct packed {
        logic wr_en;
        logic start;
    } t_scan_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_scan_stat;

    typedef enum logic [1:0] {
        S_LOAD,
        S_START,
        S_SCAN,
        S_EMIT
    } t_state;

endpackage

[sv/brps_store_scan.sv]
// Sample store (single-port write, registered read) and the counting scan.
// Depends on brps_pkg.
module brps_store_scan
    import brps_pkg::*;
#(
    parameter int DEPTH      = 1024,
    parameter int VALUE_BITS = 32,
    localparam int IW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_scan_ctrl            i_ctrl,
    input  logic [IW-1:0]         i_wr_addr,
    input  logic [VALUE_BITS-1:0] i_wr_data,
    input  logic [CW-1:0]         i_fill,
    input  logic [VALUE_BITS-1:0] i_pivot,
    output t_scan_stat            o_stat,
    output logic [CW-1:0]         o_count
);

    logic [VALUE_BITS-1:0] mem [DEPTH];

    logic                  r_active;
    logic [IW-1:0]         r_idx;
    logic                  r_rd_vld;
    logic                  r_rd_last;
    logic [VALUE_BITS-1:0] r_rd_data;
    logic [CW-1:0]         r_cnt;
    logic                  r_done;
    logic                  issue_last;

    assign issue_last = (CW'(r_idx) + CW'(1)) == i_fill;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (r_active) begin
            r_rd_data <= mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
            r_cnt     <= '0;
            r_done    <= 1'b0;
        end else begin
            r_rd_vld  <= r_active;
            r_rd_last <= r_active && issue_last;
            r_done    <= 1'b0;
            if (i_ctrl.start) begin
                r_cnt    <= '0;
                r_idx    <= '0;
                r_active <= (i_fill != '0);
                r_done   <= (i_fill == '0);
            end else begin
                if (r_active) begin
                    if (issue_last) begin
                        r_active <= 1'b0;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                if (r_rd_vld) begin
                    if (r_rd_data <= i_pivot) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                    // count is final the cycle after the last compare
                    r_done <= r_rd_last;
                end
            end
        end
    end

    assign o_stat.busy = r_active || r_rd_vld;
    assign o_stat.done = r_done;
    assign o_count     = r_cnt;

endmodule

[sv/bisection_rank_pivot_search_top.sv]
// Top level of the bisection rank pivot search block: load, bisection control, result.
// Depends on brps_pkg, brps_store_scan and bisection_rank_pivot_search_top_macros.svh.
//
//  channel | direction | handshake                   | word
//  --------+-----------+-----------------------------+-----------------------------
//  in      | input     | i_in_valid / o_in_stall     | sample, last, target_rank
//  out     | output    | o_out_valid / i_out_stall   | pivot_value, exact_match, final_count
//
// Samples load one per cycle into the store while the block is in its load state.
// A last word starts the search: a pass sets the pivot, reads the store, waits on the
// registered read and finalises the count; at most VALUE_BITS + 1 passes, then emit.
// Input stalls for the whole search; the result register lets a new set start loading
// while a result still waits. Synchronous active-low reset; no store clearing pass.
module bisection_rank_pivot_search_top
    import brps_pkg::*;
#(
    parameter int DEPTH      = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int VB = VALUE_BITS;
    localparam logic [VB-1:0] SIGN_BIT = {1'b1, {(VB-1){1'b0}}};

    t_state          r_state, n_state;
    logic [CW-1:0]   r_fill, n_fill;
    logic [VB-1:0]   r_low, n_low;
    logic [VB-1:0]   r_high, n_high;
    logic [10:0]     r_rank, n_rank;
    logic [VB-1:0]   r_piv, n_piv;
    logic            r_out_vld, n_out_vld;
    t_out_word       r_out_word, n_out_word;

    t_scan_ctrl      scan_ctrl;
    t_scan_stat      scan_stat;
    logic [CW-1:0]   scan_count;

    logic            in_acc;
    logic [VB+31:0]  in_ext;
    logic [VB-1:0]   in_u;
    logic [VB+31:0]  piv_ext;
    logic [CW+10:0]  cnt_ext;
    logic [CW+10:0]  rank_ext;
    logic [VB-1:0]   span;
    logic            stop;

    logic            scan_win;
    logic            piv_in_win;
    logic            emit_go;
    logic            set_cleared;

    assign in_acc   = i_in_valid && (r_state == S_LOAD);
    // samples kept in offset binary so unsigned compares order them as signed
    assign in_ext   = {{VB{1'b0}}, i_in_word.sample};
    assign in_u     = in_ext[VB-1:0] ^ SIGN_BIT;
    assign piv_ext  = {32'b0, r_piv ^ SIGN_BIT};
    assign cnt_ext  = {11'b0, scan_count};
    assign rank_ext = {{CW{1'b0}}, r_rank};
    assign span     = r_high - r_low;
    assign stop     = (r_high < r_low) || (span < VB'(2)) || (cnt_ext == rank_ext);

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_low      = r_low;
        n_high     = r_high;
        n_rank     = r_rank;
        n_piv      = r_piv;
        n_out_vld  = r_out_vld && i_out_stall;
        n_out_word = r_out_word;
        scan_ctrl  = '0;
        o_in_stall = 1'b1;

        unique case (r_state)
            S_LOAD: begin
                o_in_stall = 1'b0;
                if (in_acc) begin
                    if (r_fill < CW'(DEPTH)) begin
                        scan_ctrl.wr_en = 1'b1;
                        n_fill = r_fill + CW'(1);
                        if (in_u < r_low) begin
                            n_low = in_u;
                        end
                        if (in_u > r_high) begin
                            n_high = in_u;
                        end
                    end
                    if (i_in_word.last) begin
                        n_rank  = i_in_word.target_rank;
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                // overflow-free floor average
                n_piv = (r_low & r_high) + ((r_low ^ r_high) >> 1);
                scan_ctrl.start = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (scan_stat.done) begin
                    if (stop) begin
                        n_state = S_EMIT;
                    end else begin
                        if (rank_ext < cnt_ext) begin
                            n_high = r_piv;
                        end else begin
                            n_low = r_piv;
                        end
                        n_state = S_START;
                    end
                end
            end
            S_EMIT: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld              = 1'b1;
                    n_out_word.pivot_value = piv_ext[31:0];
                    n_out_word.exact_match = (cnt_ext == rank_ext);
                    n_out_word.final_count = cnt_ext[10:0];
                    n_fill  = '0;
                    n_low   = '1;
                    n_high  = '0;
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_fill    <= '0;
            r_low     <= '1;
            r_high    <= '0;
            r_rank    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_low     <= n_low;
            r_high    <= n_high;
            r_rank    <= n_rank;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_piv      <= n_piv;
        r_out_word <= n_out_word;
    end

    brps_store_scan #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_store_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (scan_ctrl),
        .i_wr_addr (r_fill[IW-1:0]),
        .i_wr_data (in_u),
        .i_fill    (r_fill),
        .i_pivot   (r_piv),
        .o_stat    (scan_stat),
        .o_count   (scan_count)
    );

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

    assign scan_win    = (r_state == S_SCAN) && (r_low <= r_high);
    assign piv_in_win  = (r_low <= r_piv) && (r_piv <= r_high);
    assign emit_go     = (r_state == S_EMIT) && (!r_out_vld || !i_out_stall);
    assign set_cleared = o_out_valid && (r_fill == '0) && (r_state == S_LOAD);

`include "bisection_rank_pivot_search_top_macros.svh"

    `BRPS_ASSERT_NOW(a_pivot_in_window, scan_win, piv_in_win, "pivot outside search window")
    `BRPS_ASSERT_NEXT(a_emit_clears, emit_go, set_cleared, "result not emitted or set not cleared")
    `BRPS_ASSERT_NOW(a_scan_idle_in_load, (r_state == S_LOAD), !scan_stat.busy, "scan busy in load")

endmodule

[dv/bisection_rank_pivot_search_top_test.sv]
`timescale 1ns / 100ps
// Testbench for bisection_rank_pivot_search_top: random sample sets with target ranks,
// checked against an in-bench bisection predictor. Depends on brps_pkg and the top level.
module bisection_rank_pivot_search_top_test;
    import brps_pkg::*;

    localparam int        DEPTH       = 1024;
    localparam int        VALUE_BITS  = 32;
    localparam bit [31:0] SIGN_FLIP   = 32'h8000_0000;
    localparam int        ITEMS       = 1950;
    localparam int        BIG_SET_AT  = 40;
    localparam int        QUIET_LEFT  = 150;
    localparam int        HOLD_CYCLES = 3000;
    localparam int        SETTLE      = 100;
    localparam int        LIMIT       = 1_500_000;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out_word;

    // pending input words and expected result words
    t_in_word  sample_q[$];
    t_out_word pivot_expect_q[$];

    // predictor state, values held in offset binary so unsigned compares order them
    bit [31:0] stored_vals[DEPTH];
    int        fill_level = 0;
    bit [31:0] min_seen   = '1;
    bit [31:0] max_seen   = '0;

    int n_items     = 0;
    int n_sets      = 0;
    int n_accepted  = 0;
    int n_results   = 0;
    int n_exact     = 0;
    int n_errors    = 0;
    int cycle_count = 0;
    int gap_left    = 0;
    int stall_left  = 0;
    int hold_left   = 0;
    int holds_done  = 0;
    bit gaps_on     = 1'b1;
    bit stalls_on   = 1'b1;
    bit quiet       = 1'b0;

    bisection_rank_pivot_search_top #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int count_le(bit [31:0] piv);
        int n;
        n = 0;
        for (int k = 0; k < fill_level; k++) begin
            if (stored_vals[k] <= piv) n++;
        end
        return n;
    endfunction

    task automatic predict_selection(input t_in_word w);
        bit [31:0] u;
        bit [31:0] lo;
        bit [31:0] hi;
        bit [31:0] piv;
        int        cnt;
        t_out_word r;
        u = w.sample ^ SIGN_FLIP;
        // a full store drops the sample but still honors its last flag
        if (fill_level < DEPTH) begin
            stored_vals[fill_level] = u;
            fill_level++;
            if (u < min_seen) min_seen = u;
            if (u > max_seen) max_seen = u;
        end
        if (w.last) begin
            lo = min_seen;
            hi = max_seen;
            while (1) begin
                piv = (lo & hi) + ((lo ^ hi) >> 1);
                cnt = count_le(piv);
                if (hi < lo || hi - lo < 2) break;
                if (cnt == w.target_rank) break;
                if (w.target_rank < cnt) hi = piv;
                else lo = piv;
            end
            r.pivot_value = piv ^ SIGN_FLIP;
            r.exact_match = (cnt == w.target_rank);
            r.final_count = cnt[10:0];
            pivot_expect_q.push_back(r);
            fill_level = 0;
            min_seen   = '1;
            max_seen   = '0;
        end
    endtask

    task automatic push_word(input bit [31:0] s, input bit last, input int rank);
        t_in_word w;
        w.sample      = s;
        w.last        = last;
        // rank only matters on the last word; elsewhere it is noise
        w.target_rank = last ? rank[10:0] : 11'($urandom_range(0, 2047));
        sample_q.push_back(w);
        n_items++;
        if (last) n_sets++;
    endtask

    task automatic add_random_set(input int n);
        int        style;
        int        rank;
        int        pick;
        int        t;
        bit [31:0] base;
        bit [31:0] v;
        style = $urandom_range(0, 3);
        base  = $urandom;
        pick  = $urandom_range(0, 9);
        if (pick < 6) rank = $urandom_range(1, n);
        else if (pick == 6) rank = 0;
        else if (pick == 7) rank = n + 1;
        else if (pick == 8) rank = 1024;
        else rank = $urandom_range(0, 1024);
        if (rank > 1024) rank = 1024;
        for (int k = 0; k < n; k++) begin
            case (style)
                0: v = $urandom;
                1: v = base + $urandom_range(0, 15);  // tight cluster, many duplicates
                2: begin
                    case ($urandom_range(0, 3))
                        0: v = 32'h8000_0000;
                        1: v = 32'h7fff_ffff;
                        2: v = 32'h0000_0000;
                        default: v = 32'hffff_ffff;
                    endcase
                end
                default: begin
                    t = $urandom_range(0, 16);
                    v = (t - 8) * 65536;               // whole Q16.16 numbers
                end
            endcase
            push_word(v, k == n - 1, rank);
        end
    endtask

    task automatic build_stimulus();
        int set_idx;
        // single-sample sets at both extremes
        push_word(32'h7fff_ffff, 1'b1, 1);
        push_word(32'h8000_0000, 1'b1, 0);
        // all equal
        push_word(32'h0, 1'b0, 0);
        push_word(32'h0, 1'b0, 0);
        push_word(32'h0, 1'b1, 3);
        // full value range, two ranks
        push_word(32'h8000_0000, 1'b0, 0);
        push_word(32'h7fff_ffff, 1'b1, 1);
        push_word(32'h8000_0000, 1'b0, 0);
        push_word(32'h7fff_ffff, 1'b1, 2);
        push_word(32'hffff_ffff, 1'b0, 0);
        push_word(32'h0000_0000, 1'b0, 0);
        push_word(32'h0000_0001, 1'b0, 0);
        push_word(32'h0000_0002, 1'b0, 0);
        push_word(32'h1234_5678, 1'b1, 2);
        // rank beyond the set size never matches
        push_word(32'h0005_0000, 1'b0, 0);
        push_word(32'h0006_0000, 1'b0, 0);
        push_word(32'h0007_0000, 1'b0, 0);
        push_word(32'h0008_0000, 1'b1, 1024);
        // rank zero
        push_word(32'h0003_0000, 1'b0, 0);
        push_word(32'hfffd_0000, 1'b0, 0);
        push_word(32'h0000_0000, 1'b1, 0);

        set_idx = 0;
        while (n_items < ITEMS) begin
            if (set_idx == BIG_SET_AT) add_random_set(DEPTH + 3);  // overflows the store
            else if ($urandom_range(0, 7) == 0) add_random_set($urandom_range(13, 64));
            else add_random_set($urandom_range(1, 12));
            set_idx++;
        end
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left   <= 0;
        end else begin
            quiet <= (sample_q.size() < QUIET_LEFT);
            if ($urandom_range(0, 63) == 0) gaps_on <= !gaps_on;
            if (i_in_valid && !o_in_stall) begin
                predict_selection(i_in_word);
                n_accepted <= n_accepted + 1;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left != 0) begin
                    gap_left   <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (!quiet && gaps_on && $urandom_range(0, 5) == 0) begin
                    gap_left   <= $urandom_range(0, 9);
                    i_in_valid <= 1'b0;
                end else if (sample_q.size() != 0) begin
                    i_in_word  <= sample_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-offs so the result register backs up into the input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left  <= 0;
            holds_done <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (holds_done < 2 && n_results >= 20 + 40 * holds_done) begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                n_results <= n_results + 1;
                if (pivot_expect_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("ERROR: unexpected result word pivot=%h exact=%0d count=%0d",
                                 o_out_word.pivot_value, o_out_word.exact_match,
                                 o_out_word.final_count);
                end else begin
                    want = pivot_expect_q.pop_front();
                    if (want.exact_match) n_exact++;
                    if (o_out_word.pivot_value !== want.pivot_value ||
                        o_out_word.exact_match !== want.exact_match ||
                        o_out_word.final_count !== want.final_count) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display({"ERROR: result %0d pivot=%h exact=%0d count=%0d,",
                                      " expected pivot=%h exact=%0d count=%0d"},
                                     n_results, o_out_word.pivot_value,
                                     o_out_word.exact_match, o_out_word.final_count,
                                     want.pivot_value, want.exact_match, want.final_count);
                    end
                end
            end
            if ($urandom_range(0, 63) == 0) stalls_on <= !stalls_on;
            if (hold_left != 0) begin
                i_out_stall <= 1'b1;
            end else if (stall_left != 0) begin
                stall_left  <= stall_left - 1;
                i_out_stall <= 1'b1;
            end else if (!quiet && stalls_on && $urandom_range(0, 4) == 0) begin
                stall_left  <= $urandom_range(0, 9);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT) begin
            $display("ERROR: timeout, %0d results still expected", pivot_expect_q.size());
            $display("bisection_rank_pivot_search_top verification failed");
            $finish;
        end
    end

    initial begin
        build_stimulus();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (sample_q.size() != 0 || i_in_valid) @(posedge i_clk);
        while (pivot_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        $display("Covered %0d sample words in %0d sets (one overflowing the store), %0d results",
                 n_accepted, n_sets, n_results);
        $display("checked, %0d exact rank hits, %0d long output hold-offs.", n_exact, holds_done);
        if (n_errors == 0 && pivot_expect_q.size() == 0) begin
            $display("bisection_rank_pivot_search_top verification clean");
        end else begin
            $display("ERROR: %0d failures, %0d results missing", n_errors, pivot_expect_q.size());
            $display("bisection_rank_pivot_search_top verification failed");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/brps_pkg.sv
sv/brps_store_scan.sv
sv/bisection_rank_pivot_search_top.sv
dv/bisection_rank_pivot_search_top_test.sv
